/* src/akwd_pkg.sv */
package akwd_pkg;

   // Widths fixed by the item and register layouts
   localparam int unsigned KEY_W      = 3;
   localparam int unsigned CNT_W      = 8;
   localparam int unsigned WIN_W      = 24;
   localparam int unsigned WIN_FIELD_W = 12;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned NUM_WIN    = 6;

   // Defaults for the top-level parameters
   localparam int unsigned NUM_KEYS_DEF = 6;
   localparam int unsigned ADC_BITS_DEF = 12;

   // Raw converter word width on the request side
   localparam int unsigned SAMPLE_W = 16;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_NONE     = 3'd0;
   localparam logic [KEY_W-1:0] KEY_VOL_DOWN = 3'd1;
   localparam logic [KEY_W-1:0] KEY_VOL_UP   = 3'd2;
   localparam logic [KEY_W-1:0] KEY_CH_DOWN  = 3'd3;
   localparam logic [KEY_W-1:0] KEY_CH_UP    = 3'd4;
   localparam logic [KEY_W-1:0] KEY_MODE     = 3'd5;
   localparam logic [KEY_W-1:0] KEY_OFF      = 3'd6;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_SCAN_MODE       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DEBOUNCE_COUNT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_VOL_DOWN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_VOL_UP   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_CH_DOWN  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_CH_UP    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_MODE_KEY = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_RELEASED = 3'd7;

   // Request function codes
   localparam logic FUNC_SCAN  = 1'b0;
   localparam logic FUNC_RESET = 1'b1;

   // Scan modes
   localparam logic MODE_NORMAL   = 1'b0;
   localparam logic MODE_LINETOOL = 1'b1;

   // Reset value of the debounce count register
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd3;

   typedef logic [WIN_W-1:0] win_type;

endpackage

/* src/adc_key_window_debounce.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_tvalid/tready    tuser: func; tdata: read_ok, adc_sample
// rsp       out        rsp_tvalid/tready    tdata: status, key_code, key_on
// csr       in         csr_we (no wait)     csr_addr, csr_wdata
//
// One request is taken per cycle unless the response side stalls; each gives
// exactly one response, through an input register and a result register.
// The rate is set by the single pass of window compares and debounce update
// between those registers; the detection state is updated as a request leaves
// the input register, so consecutive requests see each other's effect.
// Reset is synchronous and active high; it restores the CSRs, valid flags and state.
// When rsp_tready is low the result register holds, the input register fills,
// and req_tready falls only once both are occupied.
module adc_key_window_debounce #(
   parameter int unsigned NUM_KEYS = akwd_pkg::NUM_KEYS_DEF,
   parameter int unsigned ADC_BITS = akwd_pkg::ADC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [0] read_ok, [16:1] adc_sample, [23:17] zero
   input  logic        req_tuser,   // [0] func
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] status, [3:1] key_code, [4] key_on, [7:5] zero
   // Configuration port
   input  logic                              csr_we,
   input  logic [akwd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [akwd_pkg::WIN_W-1:0]        csr_wdata
);

   localparam int unsigned KW = akwd_pkg::KEY_W;
   localparam int unsigned CW = akwd_pkg::CNT_W;

   // Configuration registers
   logic              scan_mode_ff;
   logic [CW-1:0]     debounce_ff;
   akwd_pkg::win_type win_ff [akwd_pkg::NUM_WIN];

   // Input register
   logic                                 in_valid_ff;
   logic                                 in_func_ff;
   logic                                 in_read_ok_ff;
   logic [akwd_pkg::SAMPLE_W-1:0]        in_sample_ff;

   // Detection state
   logic [KW-1:0] cand_ff, cand_in;
   logic [CW-1:0] count_ff, count_in;
   logic [KW-1:0] conf_ff, conf_in;

   // Result register
   logic          out_valid_ff;
   logic          out_status_ff, out_status_in;
   logic [KW-1:0] out_key_ff, out_key_in;
   logic          out_on_ff, out_on_in;

   logic          out_load;
   logic          in_advance;
   logic [KW-1:0] match_key;
   logic [CW-1:0] threshold;
   logic          report;

   // The result register loads whenever it is empty or being drained; the
   // input register moves on at the same moment.
   assign out_load   = !out_valid_ff || rsp_tready;
   assign in_advance = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff <= akwd_pkg::MODE_NORMAL;
         debounce_ff  <= akwd_pkg::DEBOUNCE_RESET;
         for (int i = 0; i < akwd_pkg::NUM_WIN; i++) begin
            win_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_addr)
            akwd_pkg::REG_SCAN_MODE:       scan_mode_ff <= csr_wdata[0];
            akwd_pkg::REG_DEBOUNCE_COUNT:  debounce_ff  <= csr_wdata[CW-1:0];
            akwd_pkg::REG_WINDOW_VOL_DOWN: win_ff[0]    <= csr_wdata;
            akwd_pkg::REG_WINDOW_VOL_UP:   win_ff[1]    <= csr_wdata;
            akwd_pkg::REG_WINDOW_CH_DOWN:  win_ff[2]    <= csr_wdata;
            akwd_pkg::REG_WINDOW_CH_UP:    win_ff[3]    <= csr_wdata;
            akwd_pkg::REG_WINDOW_MODE_KEY: win_ff[4]    <= csr_wdata;
            akwd_pkg::REG_WINDOW_RELEASED: win_ff[5]    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register: the payload only needs loading, the valid flag resets.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff    <= req_tuser;
         in_read_ok_ff <= req_tdata[0];
         in_sample_ff  <= req_tdata[16:1];
      end
   end

   // The converter word is masked to ADC_BITS before the window compare.
   akwd_match #(
      .NUM_KEYS (NUM_KEYS),
      .ADC_BITS (ADC_BITS)
   ) u_match (
      .sample   (in_sample_ff[ADC_BITS-1:0]),
      .windows  (win_ff),
      .key_code (match_key)
   );

   assign threshold = debounce_ff - CW'(1);

   // Detection update. A reset request clears the state and reports done.
   // A failed read or an unmatched voltage leaves everything as it is. In
   // linetool mode any change of key is reported straight away; in normal
   // mode a key is counted until it has repeated up to the threshold and is
   // then reported once if it differs from the last confirmed key.
   always_comb begin
      cand_in  = cand_ff;
      count_in = count_ff;
      conf_in  = conf_ff;
      report   = 1'b0;
      if (in_func_ff == akwd_pkg::FUNC_RESET) begin
         cand_in  = akwd_pkg::KEY_OFF;
         count_in = '0;
         conf_in  = akwd_pkg::KEY_OFF;
      end else if (in_read_ok_ff && (match_key != akwd_pkg::KEY_NONE)) begin
         if (scan_mode_ff == akwd_pkg::MODE_LINETOOL) begin
            if (match_key != cand_ff) begin
               cand_in = match_key;
               report  = 1'b1;
            end
         end else begin
            if (match_key != cand_ff) begin
               cand_in  = match_key;
               count_in = CW'(1);
            end else if (debounce_ff != '0) begin
               if (count_ff < threshold) begin
                  count_in = count_ff + CW'(1);
               end else if ((count_ff == threshold) && (conf_ff != cand_ff)) begin
                  conf_in = cand_ff;
                  report  = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      out_status_in = 1'b1;
      out_key_in    = akwd_pkg::KEY_NONE;
      out_on_in     = 1'b0;
      if (in_func_ff == akwd_pkg::FUNC_RESET) begin
         out_status_in = 1'b0;
      end else if (report) begin
         out_status_in = 1'b0;
         out_key_in    = match_key;
         out_on_in     = (match_key != akwd_pkg::KEY_OFF);
      end
   end

   // State only moves when a request leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff  <= akwd_pkg::KEY_OFF;
         count_ff <= '0;
         conf_ff  <= akwd_pkg::KEY_OFF;
      end else if (in_advance) begin
         cand_ff  <= cand_in;
         count_ff <= count_in;
         conf_ff  <= conf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         out_status_ff <= out_status_in;
         out_key_ff    <= out_key_in;
         out_on_ff     <= out_on_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_on_ff, out_key_ff, out_status_ff};

endmodule

/* src/akwd_match.sv */
module akwd_match #(
   parameter int unsigned NUM_KEYS = akwd_pkg::NUM_KEYS_DEF,
   parameter int unsigned ADC_BITS = akwd_pkg::ADC_BITS_DEF
) (
   input  logic [ADC_BITS-1:0]        sample,
   input  akwd_pkg::win_type          windows [akwd_pkg::NUM_WIN],
   output logic [akwd_pkg::KEY_W-1:0] key_code
);

   // Compare width wide enough for both the sample and the window fields
   localparam int unsigned CMP_W = (ADC_BITS > akwd_pkg::WIN_FIELD_W) ?
                                   ADC_BITS : akwd_pkg::WIN_FIELD_W;
   localparam int unsigned NUM_CMP = (NUM_KEYS < akwd_pkg::NUM_WIN) ?
                                     NUM_KEYS : akwd_pkg::NUM_WIN;

   logic [CMP_W-1:0] value;
   logic [CMP_W-1:0] lo [NUM_CMP];
   logic [CMP_W-1:0] hi [NUM_CMP];
   logic [NUM_CMP-1:0] hit;

   assign value = CMP_W'(sample);

   always_comb begin
      for (int i = 0; i < NUM_CMP; i++) begin
         lo[i]  = CMP_W'(windows[i][akwd_pkg::WIN_FIELD_W-1:0]);
         hi[i]  = CMP_W'(windows[i][2*akwd_pkg::WIN_FIELD_W-1:akwd_pkg::WIN_FIELD_W]);
         hit[i] = (value >= lo[i]) && (value <= hi[i]);
      end
   end

   // First window that matches wins: scan from the last down.
   always_comb begin
      key_code = akwd_pkg::KEY_NONE;
      for (int i = NUM_CMP - 1; i >= 0; i--) begin
         if (hit[i]) begin
            key_code = akwd_pkg::KEY_W'(i + 1);
         end
      end
   end

endmodule
